### hdl/mavc_pkg.sv
// ----------------------------------------------------------------------------
// mavc_pkg
// Shared widths, register indexes and constants of the calibrated moving
// average block.
// ----------------------------------------------------------------------------
package mavc_pkg;

  localparam int unsigned SampleW  = 14;
  localparam int unsigned VoltW    = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CodeW    = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWindowCode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOffset     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMultiplier = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDivisor    = 2'd3;

  // reset values
  localparam logic [CodeW-1:0] CodeReset       = 4'd9;
  localparam logic [CfgW-1:0]  OffsetReset     = 16'd0;
  localparam logic [CfgW-1:0]  MultiplierReset = 16'd1;
  localparam logic [CfgW-1:0]  DivisorReset    = 16'd1;

  // window is 2^(code + WinShiftBase) samples
  localparam int unsigned WinShiftBase = 3;

  // millivolt scale: value = sum * 55 / (21 * window)
  localparam logic [CfgW-1:0] ScaleDen = 16'd21;

  localparam logic [VoltW-1:0] VoltMax = 16'hFFFF;

endpackage

### hdl/mavc_if.sv
// ----------------------------------------------------------------------------
// mavc_in_if / mavc_out_if
// Valid/ready channels carrying samples in and calibrated voltages out.
// ----------------------------------------------------------------------------
interface mavc_in_if;
  logic                          valid;
  logic                          ready;
  logic [mavc_pkg::SampleW-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mavc_out_if;
  logic                          valid;
  logic                          ready;
  logic [mavc_pkg::VoltW-1:0]    voltage;
  logic                          clamped;

  modport source (output valid, output voltage, output clamped, input ready);
  modport sink   (input valid, input voltage, input clamped, output ready);
endinterface

### hdl/mavc_ram.sv
// ----------------------------------------------------------------------------
// mavc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mavc_ram #(
  parameter int unsigned Width = 14,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mavc_div.sv
// ----------------------------------------------------------------------------
// mavc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavc_div #(
  parameter int unsigned DivdW = 33,
  parameter int unsigned DivsW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivdW-1:0] dividend_i,
  input  logic [DivsW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivdW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DivdW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivdW-1:0] quo_q, quo_d;
  logic [DivsW:0]   rem_q, rem_d;
  logic [DivsW-1:0] dvs_q, dvs_d;

  logic [DivsW:0]   rem_sh;
  logic             ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[DivsW-1:0], quo_q[DivdW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivdW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[DivdW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hdl/moving_average_calibrated_voltage.sv
// ----------------------------------------------------------------------------
// moving_average_calibrated_voltage
// Boxcar average of converter samples, scaled to millivolts and calibrated
// with offset, gain and divisor; result clamped to 16 bits with a flag.
// ----------------------------------------------------------------------------
//  channel    dir  beat payload        handshake
//  sample_i   in   sample (14b)        valid/ready
//  result_o   out  voltage, clamped    valid/ready
//  cfg        in   addr, wdata (16b)   cfg_we_i, no back-pressure
//
//  A new sample is accepted only while idle, once the previous one has been
//  through both divisions on the shared serial divider. DW, the dividend
//  width, is max(14+log2(MAX_WINDOW)+6, 33). The first sample and every
//  window change add one ring write per window entry. Reset clears
//  configuration and control state only; the sample ring is filled before
//  use. A finished result sits in the output register; the next sample is
//  taken meanwhile and the block stalls only when its own result is ready
//  and the previous one is still not taken.
// ----------------------------------------------------------------------------
module moving_average_calibrated_voltage #(
  parameter int unsigned MAX_WINDOW = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mavc_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [mavc_pkg::CfgW-1:0]      cfg_wdata_i,
  mavc_in_if.sink                        sample_i,
  mavc_out_if.source                     result_o
);

  import mavc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned SumW  = SampleW + AW;
  localparam int unsigned ProdW = 35;
  localparam int unsigned DW    = (SumW + 6 > 33) ? SumW + 6 : 33;
  localparam int unsigned ShW   = CodeW + 1;
  localparam logic [CodeW-1:0] MaxCode = CodeW'(AW - WinShiftBase);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StFill  = 4'd1;
  localparam logic [3:0] StRead  = 4'd2;
  localparam logic [3:0] StUpd   = 4'd3;
  localparam logic [3:0] StDiv1  = 4'd4;
  localparam logic [3:0] StWait1 = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;
  localparam logic [3:0] StDiv2  = 4'd7;
  localparam logic [3:0] StWait2 = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  function automatic logic [ShW-1:0] win_shift(input logic [CodeW-1:0] code);
    win_shift = {1'b0, code} + ShW'(WinShiftBase);
  endfunction

  // configuration
  logic [CodeW-1:0] window_code_q;
  logic [CfgW-1:0]  offset_q, mult_q, divisor_q;

  // control state
  logic [3:0]       state_q, state_d;
  logic             primed_q, primed_d;
  logic [CodeW-1:0] active_q, active_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [AW-1:0]    fill_cnt_q, fill_cnt_d;
  logic             fill_to_read_q, fill_to_read_d;
  logic             out_valid_q, out_valid_d;

  // payload
  logic [SampleW-1:0]      sample_q, sample_d;
  logic [SampleW-1:0]      fill_val_q, fill_val_d;
  logic signed [17:0]      addend_q, addend_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                    neg_q, neg_d;
  logic [VoltW-1:0]        res_volt_q, res_volt_d;
  logic                    res_flag_q, res_flag_d;
  logic [VoltW-1:0]        out_volt_q, out_volt_d;
  logic                    out_flag_q, out_flag_d;

  // datapath helpers
  logic [CodeW-1:0]   code_eff;
  logic [AW:0]        win_full;
  logic [AW-1:0]      win_mask;
  logic [SampleW-1:0] mean;
  logic [DW-1:0]      sum_ext;
  logic [ProdW-1:0]   prod_mag;
  logic [VoltW-1:0]   value;

  // ring and divider
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SampleW-1:0] ram_wdata;
  logic [SampleW-1:0] ram_rdata;
  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [CfgW-1:0]    div_divisor;
  logic               div_done;
  logic [DW-1:0]      div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_code_q <= CodeReset;
      offset_q      <= OffsetReset;
      mult_q        <= MultiplierReset;
      divisor_q     <= DivisorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegWindowCode: window_code_q <= cfg_wdata_i[CodeW-1:0];
        RegOffset:     offset_q      <= cfg_wdata_i;
        RegMultiplier: mult_q        <= cfg_wdata_i;
        RegDivisor:    divisor_q     <= cfg_wdata_i;
      endcase
    end
  end

  assign code_eff = (window_code_q > MaxCode) ? MaxCode : window_code_q;
  assign win_full = (AW+1)'(1) << win_shift(active_q);
  assign win_mask = win_full[AW-1:0] - AW'(1);
  assign mean     = SampleW'(sum_q >> win_shift(active_q));
  assign sum_ext  = DW'(sum_q);
  // |product|; the sign is kept separately
  assign prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
  assign value    = VoltW'(div_quo >> win_shift(active_q));

  assign sample_i.ready = (state_q == StIdle);

  always_comb begin
    state_d        = state_q;
    primed_d       = primed_q;
    active_d       = active_q;
    sum_d          = sum_q;
    wp_d           = wp_q;
    fill_cnt_d     = fill_cnt_q;
    fill_to_read_d = fill_to_read_q;
    out_valid_d    = out_valid_q;
    sample_d       = sample_q;
    fill_val_d     = fill_val_q;
    addend_d       = addend_q;
    prod_d         = prod_q;
    neg_d          = neg_q;
    res_volt_d     = res_volt_q;
    res_flag_d     = res_flag_q;
    out_volt_d     = out_volt_q;
    out_flag_d     = out_flag_q;
    ram_we         = 1'b0;
    ram_waddr      = wp_q;
    ram_wdata      = sample_q;
    div_start      = 1'b0;
    div_dividend   = (sum_ext << 6) - (sum_ext << 3) - sum_ext;  // sum * 55
    div_divisor    = ScaleDen;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (sample_i.valid) begin
          sample_d   = sample_i.sample;
          fill_cnt_d = '0;
          if (!primed_q) begin
            // first sample fills the whole window with itself
            primed_d       = 1'b1;
            active_d       = code_eff;
            fill_val_d     = sample_i.sample;
            sum_d          = SumW'(sample_i.sample) << win_shift(code_eff);
            wp_d           = AW'(1);
            fill_to_read_d = 1'b0;
            state_d        = StFill;
          end else if (code_eff != active_q) begin
            // window change: refill with the old mean
            active_d       = code_eff;
            fill_val_d     = mean;
            sum_d          = SumW'(mean) << win_shift(code_eff);
            wp_d           = '0;
            fill_to_read_d = 1'b1;
            state_d        = StFill;
          end else begin
            state_d = StRead;
          end
        end
      end
      StFill: begin
        ram_we     = 1'b1;
        ram_waddr  = fill_cnt_q;
        ram_wdata  = fill_val_q;
        fill_cnt_d = fill_cnt_q + AW'(1);
        if (fill_cnt_q == win_mask) begin
          state_d = fill_to_read_q ? StRead : StDiv1;
        end
      end
      StRead: begin
        state_d = StUpd;
      end
      StUpd: begin
        ram_we  = 1'b1;
        sum_d   = sum_q - SumW'(ram_rdata) + SumW'(sample_q);
        wp_d    = (wp_q + AW'(1)) & win_mask;
        state_d = StDiv1;
      end
      StDiv1: begin
        div_start = 1'b1;
        state_d   = StWait1;
      end
      StWait1: begin
        if (div_done) begin
          addend_d = $signed({2'b00, value}) + $signed({{2{offset_q[CfgW-1]}}, offset_q});
          state_d  = StMul;
        end
      end
      StMul: begin
        prod_d  = ProdW'(addend_q * $signed({1'b0, mult_q}));
        state_d = StDiv2;
      end
      StDiv2: begin
        div_start    = 1'b1;
        div_dividend = DW'(prod_mag);
        div_divisor  = (divisor_q == '0) ? CfgW'(1) : divisor_q;
        neg_d        = prod_q[ProdW-1];
        state_d      = StWait2;
      end
      StWait2: begin
        div_divisor = (divisor_q == '0) ? CfgW'(1) : divisor_q;
        if (div_done) begin
          priority if (neg_q) begin
            // truncation toward zero: a zero quotient is not clamped
            res_volt_d = '0;
            res_flag_d = |div_quo;
          end else if (|div_quo[DW-1:VoltW]) begin
            res_volt_d = VoltMax;
            res_flag_d = 1'b1;
          end else begin
            res_volt_d = div_quo[VoltW-1:0];
            res_flag_d = 1'b0;
          end
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_volt_d  = res_volt_q;
          out_flag_d  = res_flag_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      primed_q       <= 1'b0;
      active_q       <= CodeReset;
      sum_q          <= '0;
      wp_q           <= '0;
      fill_cnt_q     <= '0;
      fill_to_read_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      primed_q       <= primed_d;
      active_q       <= active_d;
      sum_q          <= sum_d;
      wp_q           <= wp_d;
      fill_cnt_q     <= fill_cnt_d;
      fill_to_read_q <= fill_to_read_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    fill_val_q <= fill_val_d;
    addend_q   <= addend_d;
    prod_q     <= prod_d;
    neg_q      <= neg_d;
    res_volt_q <= res_volt_d;
    res_flag_q <= res_flag_d;
    out_volt_q <= out_volt_d;
    out_flag_q <= out_flag_d;
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.voltage = out_volt_q;
  assign result_o.clamped = out_flag_q;

  mavc_ram #(
    .Width (SampleW),
    .Depth (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (wp_q),
    .rdata_o (ram_rdata)
  );

  mavc_div #(
    .DivdW (DW),
    .DivsW (CfgW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calibrated moving average. Samples go in over
// the valid/ready channel with random gaps, results are pulled out with
// random stalls, and every result beat is compared with a bit-exact
// prediction of the boxcar window, the millivolt scaling and the offset,
// gain and divisor calibration with its clamp. Calibration is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import mavc_pkg::*;

  localparam int unsigned MaxWindow  = 4096;
  localparam int unsigned MaxCode    = $clog2(MaxWindow) - WinShiftBase;
  localparam int unsigned ScaleNum   = 55;
  localparam int          SampleMax  = (1 << SampleW) - 1;
  localparam int unsigned ItemTarget = 1650;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned StallLimit = 50000;
  localparam int unsigned TailCycles = 200;

  typedef struct packed {
    logic [VoltW-1:0] voltage;
    logic             clamped;
  } volt_beat_t;

  // Predicts the averaged, calibrated voltage for each accepted sample and
  // holds the results still owed by the block.
  class volt_scoreboard;
    logic [SampleW-1:0] ring [MaxWindow];
    longint unsigned    win_sum;
    int unsigned        wr_pos;
    bit                 primed;
    int unsigned        cur_code;
    logic [CodeW-1:0]   code_reg;
    logic [CfgW-1:0]    offset_reg;
    logic [CfgW-1:0]    gain_reg;
    logic [CfgW-1:0]    divisor_reg;
    volt_beat_t         due[$];
    int unsigned        n_checked;
    int unsigned        n_clamped;
    int unsigned        n_refills;
    int unsigned        n_errors;

    function new();
      win_sum     = 0;
      wr_pos      = 0;
      primed      = 1'b0;
      cur_code    = CodeReset;
      code_reg    = CodeReset;
      offset_reg  = OffsetReset;
      gain_reg    = MultiplierReset;
      divisor_reg = DivisorReset;
      n_checked   = 0;
      n_clamped   = 0;
      n_refills   = 0;
      n_errors    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        RegWindowCode: code_reg    = data[CodeW-1:0];
        RegOffset:     offset_reg  = data;
        RegMultiplier: gain_reg    = data;
        RegDivisor:    divisor_reg = data;
        default: ;
      endcase
    endfunction

    function void fill_ring(int unsigned code, logic [SampleW-1:0] level);
      for (int i = 0; i < (1 << (code + WinShiftBase)); i++) ring[i] = level;
      win_sum = longint'(level) << (code + WinShiftBase);
    endfunction

    function void take_sample(logic [SampleW-1:0] s);
      int unsigned        code;
      int unsigned        win;
      logic [SampleW-1:0] mean;
      longint unsigned    scaled;
      longint             cal;
      longint             dv;
      volt_beat_t         beat;
      code = (code_reg > MaxCode) ? MaxCode : code_reg;
      if (!primed) begin
        // first sample stands for the whole window
        cur_code = code;
        fill_ring(code, s);
        win    = 1 << (code + WinShiftBase);
        wr_pos = 1 & (win - 1);
        primed = 1'b1;
      end else begin
        if (code != cur_code) begin
          // new window starts out full of the old mean
          mean     = SampleW'(win_sum >> (cur_code + WinShiftBase));
          cur_code = code;
          fill_ring(code, mean);
          wr_pos   = 0;
          n_refills++;
        end
        win     = 1 << (cur_code + WinShiftBase);
        wr_pos  = wr_pos & (win - 1);
        win_sum = win_sum - ring[wr_pos] + s;
        ring[wr_pos] = s;
        wr_pos  = (wr_pos + 1) & (win - 1);
      end
      win    = 1 << (cur_code + WinShiftBase);
      scaled = (win_sum * ScaleNum) / (longint'(ScaleDen) * win);
      dv     = (divisor_reg == '0) ? 64'sd1 : longint'(divisor_reg);
      cal    = (longint'(scaled) + longint'($signed(offset_reg)))
               * longint'(gain_reg) / dv;
      if (cal < 0) begin
        beat.voltage = '0;
        beat.clamped = 1'b1;
      end else if (cal > longint'(VoltMax)) begin
        beat.voltage = VoltMax;
        beat.clamped = 1'b1;
      end else begin
        beat.voltage = VoltW'(cal);
        beat.clamped = 1'b0;
      end
      due.push_back(beat);
    endfunction

    task report_mismatch(string what);
      n_errors++;
      if (n_errors <= 30) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_voltage(volt_beat_t got);
      volt_beat_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("result beat with no sample pending: voltage=%0d clamped=%0b",
                                  got.voltage, got.clamped));
        return;
      end
      want = due.pop_front();
      n_checked++;
      if (want.clamped) n_clamped++;
      if (got.voltage !== want.voltage)
        report_mismatch($sformatf("voltage %0d, predicted %0d", got.voltage, want.voltage));
      if (got.clamped !== want.clamped)
        report_mismatch($sformatf("clamped %0b, predicted %0b", got.clamped, want.clamped));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [CfgW-1:0]     cfg_wdata_i;

  mavc_in_if  sample_ch ();
  mavc_out_if result_ch ();

  volt_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;
  int unsigned    n_sent        = 0;
  int unsigned    n_settings    = 0;
  int unsigned    quiet_cycles  = 0;

  moving_average_calibrated_voltage #(
    .MAX_WINDOW (MaxWindow)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_ch),
    .result_o    (result_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready)
      sb.check_voltage('{voltage: result_ch.voltage, clamped: result_ch.clamped});
  end

  // watchdog: no beat on either channel for too long
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk_i); while (!sample_ch.ready);
    sb.take_sample(s);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    sample_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CodeW-1:0] code, input logic [CfgW-1:0] off,
                           input logic [CfgW-1:0] mul, input logic [CfgW-1:0] dv);
    logic [CfgIdxW-1:0] addrs [4];
    logic [CfgW-1:0]    vals  [4];
    addrs = '{RegWindowCode, RegOffset, RegMultiplier, RegDivisor};
    vals  = '{CfgW'(code), off, mul, dv};
    foreach (addrs[i]) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= addrs[i];
      cfg_wdata_i <= vals[i];
      sb.set_reg(addrs[i], vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic random_setting();
    logic [CodeW-1:0] code;
    logic [CfgW-1:0]  off;
    logic [CfgW-1:0]  mul;
    logic [CfgW-1:0]  dv;
    // mostly short windows, which refill fast and track the input closely
    code = ($urandom_range(9) < 7) ? CodeW'($urandom_range(4)) : CodeW'($urandom_range(15));
    case ($urandom_range(2))
      0:       off = CfgW'($urandom);
      1:       off = CfgW'($urandom_range(1000)) - CfgW'(500);
      default: off = '0;
    endcase
    case ($urandom_range(3))
      0: begin
        mul = CfgW'($urandom);
        dv  = mul ^ CfgW'($urandom_range(255));
      end
      1: begin
        mul = CfgW'($urandom);
        dv  = CfgW'($urandom);
      end
      2: begin
        mul = CfgW'($urandom_range(8));
        dv  = CfgW'($urandom_range(8));
      end
      default: begin
        mul = CfgW'($urandom_range(2000, 1000));
        dv  = CfgW'($urandom_range(65535, 1000));
      end
    endcase
    configure(code, off, mul, dv);
  endtask

  function automatic logic [SampleW-1:0] pick_sample(int level);
    int d;
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? '1 : '0;
      1, 2, 3: return SampleW'($urandom);
      default: begin
        d = level + int'($urandom_range(128)) - 64;
        if (d < 0) d = 0;
        if (d > SampleMax) d = SampleMax;
        return SampleW'(d);
      end
    endcase
  endfunction

  initial begin
    int unsigned per_phase;
    int          level;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_addr_i       = RegWindowCode;
    cfg_wdata_i      = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset calibration, first sample fills the largest window
    send_sample('1);
    send_sample('0);
    send_sample(14'h2AAA);
    send_sample(14'h1555);
    // shrink to the shortest window: refill with the old mean
    drain();
    configure(4'd0, 16'd0, 16'd1, 16'd1);
    send_sample('0);
    send_sample('1);
    send_sample('0);
    // clamp high
    drain();
    configure(4'd0, 16'h7FFF, 16'hFFFF, 16'd1);
    send_sample('1);
    send_sample(14'd8191);
    // zero divisor and clamp low
    drain();
    configure(4'd0, 16'h8000, 16'hFFFF, 16'd0);
    send_sample('0);
    send_sample('1);
    // oversized code maps to the largest window; zero gain
    drain();
    configure(4'd15, 16'd100, 16'd0, 16'd7);
    send_sample(14'd5);
    send_sample('1);
    // same effective window as above: no refill expected
    drain();
    configure(4'd9, 16'd0, 16'd1, 16'd1);
    send_sample(14'd3000);
    send_sample('1);
    drain();
    configure(4'd3, 16'hFFFB, 16'hFFFF, 16'hFFFF);
    send_sample('1);
    send_sample('0);
    send_sample(14'd77);

    per_phase = (ItemTarget - n_sent) / NumPhases;
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph == NumPhases - 1)
        configure(4'd0, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      else if (ph == NumPhases - 2)
        configure(4'd9, 16'h8000, 16'hFFFF, 16'd1);
      else
        random_setting();
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 79; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      level = $urandom_range(SampleMax);
      for (int k = 0; k < per_phase; k++) begin
        // hold off until the block has returned every result
        if (k == per_phase / 2 && ph % 3 == 1) drain();
        if ($urandom_range(31) == 0) level = $urandom_range(SampleMax);
        send_sample(pick_sample(level));
      end
    end

    drain();
    stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);
    if (sb.due.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.due.size()));

    $display("covered %0d samples over %0d calibration settings, %0d window refills",
             n_sent, n_settings, sb.n_refills);
    $display("%0d result beats checked, %0d of them clamped, %0d mismatches",
             sb.n_checked, sb.n_clamped, sb.n_errors);
    if (sb.n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
hdl/mavc_pkg.sv
hdl/mavc_if.sv
hdl/mavc_ram.sv
hdl/mavc_div.sv
hdl/moving_average_calibrated_voltage.sv
verif/tb.sv
